// ----- rtl/core/aet_pkg.sv -----
// Package for the arithmetic expression tokenizer.
// Holds field widths, token kind codes, character codes and the result word type.
// No dependencies; compile this file first.
`default_nettype none

package aet_pkg;

  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned KIND_W        = 4;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned START_W       = 16;
  localparam int unsigned LEN_W         = 16;
  localparam int unsigned DEFAULT_POSITION_BITS = 16;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_NUMBER = 4'd0,
    KIND_PLUS   = 4'd1,
    KIND_MINUS  = 4'd2,
    KIND_STAR   = 4'd3,
    KIND_PCT    = 4'd4,
    KIND_SLASH  = 4'd5,
    KIND_LPAREN = 4'd6,
    KIND_RPAREN = 4'd7,
    KIND_IDENT  = 4'd8,
    KIND_ASSIGN = 4'd9,
    KIND_SEMI   = 4'd10,
    KIND_END    = 4'd11,
    KIND_ERROR  = 4'd12
  } token_kind_e;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_ASSIGN = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;

  typedef struct packed {
    token_kind_e        kind;
    logic [VALUE_W-1:0] value;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               last;
  } token_t;

endpackage

`default_nettype wire

// ----- rtl/core/aet_char_if.sv -----
// Character channel of the tokenizer: valid, ready and one source byte.
// Depends on aet_pkg for the character width.
`default_nettype none

interface aet_char_if
  import aet_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] source_char;

  modport source (output valid, output source_char, input ready);
  modport sink   (input valid, input source_char, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/aet_token_if.sv -----
// Token channel of the tokenizer: valid, ready and the fields of one token.
// Depends on aet_pkg for the field widths.
`default_nettype none

interface aet_token_if
  import aet_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [VALUE_W-1:0] number_value;
  logic [START_W-1:0] token_start;
  logic [LEN_W-1:0]   token_length;
  logic               last_of_run;

  modport source (output valid, output token_kind, output number_value,
                  output token_start, output token_length, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input number_value,
                  input token_start, input token_length, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/arith_expression_tokenizer.sv -----
// Path: an accepted character is held in the input register, then scanned into the token
// queue, whose head slot drives the output channel. Throughput: one character per cycle
// while the queue has room; a character that closes a token and also forms a token itself
// puts out two tokens, and the two-entry token queue drains one per cycle when ready is high.
// Reset (rst_ni low, asynchronous) empties the input register and the token queue, sets
// the scanner between tokens and sets the character position to zero.
`default_nettype none

module arith_expression_tokenizer
  import aet_pkg::*;
#(
  parameter int unsigned POSITION_BITS = DEFAULT_POSITION_BITS
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  aet_char_if.sink      char_if_i,
  aet_token_if.source   token_if_o
);

  // Scanner modes. Code 3 never arises and behaves as idle.
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_NUMBER = 2'd1;
  localparam logic [1:0] MODE_IDENT  = 2'd2;

  // Input register: one source byte waiting to be scanned.
  logic              chr_valid_q;
  logic [CHAR_W-1:0] chr_q;

  // Scanner state.
  logic [1:0]               mode_q, mode_d;
  logic [VALUE_W-1:0]       acc_q, acc_d;
  logic [START_W-1:0]       ostart_q, ostart_d;
  logic [LEN_W-1:0]         olen_q, olen_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;

  // Token queue: slot 0 is the head that drives the output channel.
  token_t     slot_q [2];
  token_t     slot_d [2];
  logic [1:0] cnt_q, cnt_d;

  // Character classes of the byte in the input register.
  logic is_num, is_word, is_sep, is_nul, cont;
  logic [3:0] digit_val;
  token_kind_e op_kind;

  assign is_num    = (chr_q >= CH_ZERO) && (chr_q <= CH_NINE);
  assign is_word   = ((chr_q >= CH_LO_A) && (chr_q <= CH_LO_Z)) ||
                     ((chr_q >= CH_UP_A) && (chr_q <= CH_UP_Z)) || (chr_q == CH_UNDER);
  assign is_sep    = chr_q inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
  assign is_nul    = (chr_q == CH_NUL);
  assign digit_val = 4'(chr_q - CH_ZERO);

  // The byte extends the open token rather than closing it.
  assign cont = ((mode_q == MODE_NUMBER) && is_num) ||
                ((mode_q == MODE_IDENT) && (is_word || is_num));

  always_comb begin
    unique case (chr_q)
      CH_PLUS:   op_kind = KIND_PLUS;
      CH_MINUS:  op_kind = KIND_MINUS;
      CH_STAR:   op_kind = KIND_STAR;
      CH_PCT:    op_kind = KIND_PCT;
      CH_SLASH:  op_kind = KIND_SLASH;
      CH_LPAREN: op_kind = KIND_LPAREN;
      CH_RPAREN: op_kind = KIND_RPAREN;
      CH_ASSIGN: op_kind = KIND_ASSIGN;
      CH_SEMI:   op_kind = KIND_SEMI;
      default:   op_kind = KIND_ERROR;
    endcase
  end

  // Scan step: next state plus up to two tokens. The closed number or identifier,
  // if any, always comes first; the token formed by the byte itself follows.
  token_t     tok_a, tok_b, res0, res1;
  logic       has_a, has_b;
  logic [1:0] n_res;
  logic [VALUE_W-1:0]   acc_x10;
  logic [START_W-1:0]   pos_start;

  // Times ten as two shifts and an add, wrapping at the value width.
  assign acc_x10   = (acc_q << 3) + (acc_q << 1);
  assign pos_start = START_W'(pos_q);

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    ostart_d = ostart_q;
    olen_d   = olen_q;
    pos_d    = pos_q + 1'b1;
    tok_a    = '0;
    tok_b    = '0;
    has_a    = 1'b0;
    has_b    = 1'b0;

    if (cont) begin
      if (mode_q == MODE_NUMBER) begin
        acc_d = acc_x10 + VALUE_W'(digit_val);
      end
      if (olen_q != LEN_MAX) begin
        olen_d = olen_q + 1'b1;
      end
    end else begin
      if (mode_q == MODE_NUMBER) begin
        has_a       = 1'b1;
        tok_a.kind  = KIND_NUMBER;
        tok_a.value = acc_q;
      end else if (mode_q == MODE_IDENT) begin
        has_a       = 1'b1;
        tok_a.kind  = KIND_IDENT;
      end
      tok_a.start  = ostart_q;
      tok_a.length = olen_q;
      mode_d       = MODE_IDLE;
      acc_d        = '0;

      tok_b.start  = pos_start;
      tok_b.length = LEN_W'(1);
      if (is_nul) begin
        has_b      = 1'b1;
        tok_b.kind = KIND_END;
        pos_d      = '0;
      end else if (is_sep) begin
        has_b = 1'b0;
      end else if (is_num) begin
        mode_d   = MODE_NUMBER;
        acc_d    = VALUE_W'(digit_val);
        ostart_d = pos_start;
        olen_d   = LEN_W'(1);
      end else if (is_word) begin
        mode_d   = MODE_IDENT;
        ostart_d = pos_start;
        olen_d   = LEN_W'(1);
      end else begin
        has_b      = 1'b1;
        tok_b.kind = op_kind;
      end
    end

    n_res = 2'(has_a) + 2'(has_b);
    if (has_a) begin
      res0 = tok_a;
      res1 = tok_b;
    end else begin
      res0 = tok_b;
      res1 = tok_b;
    end
    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  // Queue bookkeeping. A byte is scanned only when all of its tokens fit in the
  // queue after this cycle's pop, so no token is ever dropped.
  logic       pop, fire;
  logic [1:0] base;
  logic [2:0] need;

  assign pop  = token_if_o.valid && token_if_o.ready;
  assign base = cnt_q - 2'(pop);
  assign need = 3'(base) + 3'(n_res);
  assign fire = chr_valid_q && (need <= 3'd2);

  // The input register refills in the same cycle that its byte is scanned.
  assign char_if_i.ready = !chr_valid_q || fire;

  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    if (pop) begin
      slot_d[0] = slot_q[1];
    end
    cnt_d = base;
    if (fire) begin
      cnt_d = need[1:0];
      if (n_res == 2'd2) begin
        slot_d[0] = res0;
        slot_d[1] = res1;
      end else if (n_res == 2'd1) begin
        if (base == 2'd0) begin
          slot_d[0] = res0;
        end else begin
          slot_d[1] = res0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_valid_q <= 1'b0;
      mode_q      <= MODE_IDLE;
      acc_q       <= '0;
      ostart_q    <= '0;
      olen_q      <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if (char_if_i.ready) begin
        chr_valid_q <= char_if_i.valid;
      end
      if (fire) begin
        mode_q   <= mode_d;
        acc_q    <= acc_d;
        ostart_q <= ostart_d;
        olen_q   <= olen_d;
        pos_q    <= pos_d;
      end
      cnt_q <= cnt_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (char_if_i.ready && char_if_i.valid) begin
      chr_q <= char_if_i.source_char;
    end
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

  assign token_if_o.valid        = (cnt_q != 2'd0);
  assign token_if_o.token_kind   = slot_q[0].kind;
  assign token_if_o.number_value = slot_q[0].value;
  assign token_if_o.token_start  = slot_q[0].start;
  assign token_if_o.token_length = slot_q[0].length;
  assign token_if_o.last_of_run  = slot_q[0].last;

`ifndef SYNTHESIS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("token queue count out of range");

  a_mode_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != 2'd3)
    else $error("scanner reached the unused mode code");

  a_nul_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_nul |=> pos_q == '0)
    else $error("position did not restart after end of string");

  a_pair_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (n_res == 2'd2) |-> (res0.kind == KIND_NUMBER) || (res0.kind == KIND_IDENT))
    else $error("token pair does not start with a closed number or identifier");

  a_pair_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) && !slot_q[0].last |-> cnt_q == 2'd2)
    else $error("first token of a pair is queued without its partner");
`endif

endmodule

`default_nettype wire
